>>> sv/base64_validating_decoder_unit_assert.svh
// Assertion macros for the Base64 validating decoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BASE64_VALIDATING_DECODER_UNIT_ASSERT_SVH
`define BASE64_VALIDATING_DECODER_UNIT_ASSERT_SVH

// Check a consequence in the same cycle.
`define B64VD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define B64VD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/b64vd_pkg.sv
// Shared types, constants and the character classifier of the Base64 decoder.
// No dependencies.
`default_nettype none

package b64vd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int OUT_COUNT_W     = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_LENGTH   = 2'd2,
        ST_PADDING  = 2'd3
    } status_t;

    typedef struct packed {
        logic       is_alpha;
        logic       is_pad;
        logic [5:0] sextet;
    } char_class_t;

    typedef struct packed {
        logic                             is_status;
        logic                             last;
        status_t                          status;
        logic [1:0]                       nbytes;
        logic [2:0][7:0]                  data;
        logic [2:0][OUT_COUNT_W-1:0]      dcount;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        logic [7:0]  d;
        r = '0;
        d = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d = c - CH_UPPER_A;
            r.is_alpha = 1'b1;
            r.sextet = d[5:0];
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d = c - CH_LOWER_A + 8'd26;
            r.is_alpha = 1'b1;
            r.sextet = d[5:0];
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            d = c - CH_DIGIT_0 + 8'd52;
            r.is_alpha = 1'b1;
            r.sextet = d[5:0];
        end else if (c == CH_PLUS) begin
            r.is_alpha = 1'b1;
            r.sextet = SEXTET_PLUS;
        end else if (c == CH_SLASH) begin
            r.is_alpha = 1'b1;
            r.sextet = SEXTET_SLASH;
        end else if (c == CH_PAD) begin
            r.is_pad = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/b64vd_front.sv
// Front end: accepts characters, validates, assembles quartets, builds jobs.
// Depends on b64vd_pkg.
`default_nettype none

module b64vd_front #(
    parameter int COUNT_WIDTH = b64vd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               char_valid,
    output logic                    char_stall,
    input  wire logic [7:0]         char_code,
    input  wire logic               final_char,
    input  wire b64vd_pkg::q_stat_t q_stat,
    output logic                    push,
    output b64vd_pkg::job_t         job
);

    import b64vd_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + 2;
    localparam logic [SUM_W-1:0] CNT_MAX = {2'b00, {COUNT_WIDTH{1'b1}}};

    logic [17:0]            acc_reg, acc_next;
    logic [1:0]             qpos_reg, qpos_next;
    logic                   pad_reg, pad_next;
    logic                   padded_reg, padded_next;
    status_t                err_reg, err_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;

    char_class_t            cls;
    logic [23:0]            quartet;
    logic [1:0]             nbytes;
    logic [2:0][7:0]        data;
    logic [SUM_W-1:0]       sum [3];
    logic [COUNT_WIDTH-1:0] cnt_sat [3];
    status_t                err_fin;
    logic                   accept;

    assign char_stall = q_stat.full;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        cls         = classify(char_code);
        quartet     = {acc_reg, cls.sextet};
        acc_next    = acc_reg;
        qpos_next   = qpos_reg;
        pad_next    = pad_reg;
        padded_next = padded_reg;
        err_next    = err_reg;
        nbytes      = 2'd0;
        data        = '0;
        if (err_reg == ST_OK)
        begin
            if (!cls.is_alpha && !cls.is_pad)
            begin
                err_next = ST_BAD_CHAR;
            end
            else if (padded_reg)
            begin
                err_next = ST_PADDING;
            end
            else if (cls.is_alpha)
            begin
                if (pad_reg)
                begin
                    err_next = ST_PADDING;
                end
                else if (qpos_reg != 2'd3)
                begin
                    acc_next  = {acc_reg[11:0], cls.sextet};
                    qpos_next = qpos_reg + 2'd1;
                end
                else
                begin
                    nbytes    = 2'd3;
                    data[0]   = quartet[23:16];
                    data[1]   = quartet[15:8];
                    data[2]   = quartet[7:0];
                    acc_next  = '0;
                    qpos_next = 2'd0;
                end
            end
            else
            begin
                if (qpos_reg < 2'd2)
                begin
                    err_next = ST_PADDING;
                end
                else if (qpos_reg == 2'd2)
                begin
                    pad_next  = 1'b1;
                    qpos_next = 2'd3;
                end
                else
                begin
                    if (pad_reg)
                    begin
                        nbytes  = 2'd1;
                        data[0] = acc_reg[11:4];
                    end
                    else
                    begin
                        nbytes  = 2'd2;
                        data[0] = acc_reg[17:10];
                        data[1] = acc_reg[9:2];
                    end
                    padded_next = 1'b1;
                    pad_next    = 1'b0;
                    acc_next    = '0;
                    qpos_next   = 2'd0;
                end
            end
        end

        for (int k = 0; k < 3; k++)
        begin
            sum[k]     = {2'b00, cnt_reg} + SUM_W'(k + 1);
            cnt_sat[k] = (sum[k] > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
                                            : sum[k][COUNT_WIDTH-1:0];
        end

        case (nbytes)
            2'd1:    cnt_next = cnt_sat[0];
            2'd2:    cnt_next = cnt_sat[1];
            2'd3:    cnt_next = cnt_sat[2];
            default: cnt_next = cnt_reg;
        endcase

        err_fin = (err_next == ST_OK && qpos_next != 2'd0) ? ST_LENGTH : err_next;

        if (final_char && err_fin != ST_OK)
        begin
            job.is_status = 1'b1;
            job.last      = 1'b1;
            job.status    = err_fin;
            job.nbytes    = 2'd1;
            job.data      = '0;
            job.dcount    = '0;
            job.dcount[0] = OUT_COUNT_W'(cnt_reg);
        end
        else
        begin
            job.is_status = 1'b0;
            job.last      = final_char;
            job.status    = ST_OK;
            job.nbytes    = nbytes;
            job.data      = data;
            for (int k = 0; k < 3; k++)
            begin
                job.dcount[k] = OUT_COUNT_W'(cnt_sat[k]);
            end
        end

        push = accept && (nbytes != 2'd0 || final_char);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            qpos_reg   <= 2'd0;
            pad_reg    <= 1'b0;
            padded_reg <= 1'b0;
            err_reg    <= ST_OK;
            cnt_reg    <= '0;
        end
        else if (accept)
        begin
            if (final_char)
            begin
                acc_reg    <= '0;
                qpos_reg   <= 2'd0;
                pad_reg    <= 1'b0;
                padded_reg <= 1'b0;
                err_reg    <= ST_OK;
                cnt_reg    <= '0;
            end
            else
            begin
                acc_reg    <= acc_next;
                qpos_reg   <= qpos_next;
                pad_reg    <= pad_next;
                padded_reg <= padded_next;
                err_reg    <= err_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/b64vd_queue.sv
// Short job queue between the front end and the result sequencer.
// Depends on b64vd_pkg.
`default_nettype none

module b64vd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire b64vd_pkg::q_ctrl_t q_ctrl,
    input  wire b64vd_pkg::job_t    push_job,
    output b64vd_pkg::job_t         head,
    output b64vd_pkg::q_stat_t      q_stat
);

    import b64vd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    job_t             entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = q_ctrl.push && !q_stat.full;
    assign do_pop       = q_ctrl.pop && !q_stat.empty;
    assign head         = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/b64vd_back.sv
// Result sequencer: unrolls each job into an output register, one result per cycle unless stalled.
// Depends on b64vd_pkg.
`default_nettype none

module b64vd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire b64vd_pkg::job_t    head,
    input  wire b64vd_pkg::q_stat_t q_stat,
    output logic                    pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [7:0]              out_byte,
    output logic                    byte_present,
    output logic                    end_of_string,
    output logic [1:0]              status,
    output logic [15:0]             decoded_count
);

    import b64vd_pkg::*;

    logic                   valid_reg;
    logic [1:0]             idx_reg;
    logic [7:0]             byte_reg;
    logic                   present_reg;
    logic                   end_reg;
    status_t                status_reg;
    logic [OUT_COUNT_W-1:0] count_reg;
    logic                   load;
    logic                   job_done;

    assign load     = !q_stat.empty && (!valid_reg || !result_stall);
    assign job_done = head.is_status || (idx_reg == head.nbytes - 2'd1);
    assign pop      = load && job_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= job_done ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= head.is_status ? 8'd0 : head.data[idx_reg];
            present_reg <= !head.is_status;
            end_reg     <= head.last && job_done;
            status_reg  <= head.status;
            count_reg   <= head.dcount[idx_reg];
        end
    end

    assign result_valid  = valid_reg;
    assign out_byte      = byte_reg;
    assign byte_present  = present_reg;
    assign end_of_string = end_reg;
    assign status        = status_reg;
    assign decoded_count = count_reg;

endmodule

`default_nettype wire

>>> sv/base64_validating_decoder_unit.sv
// Top level of the Base64 validating decoder: front end, job queue, result sequencer.
// Depends on b64vd_pkg, b64vd_front, b64vd_queue, b64vd_back and the assertion header.
`default_nettype none
`include "base64_validating_decoder_unit_assert.svh"

// Decodes a standard-alphabet Base64 string one character per cycle, checking
// alphabet, length and padding in the same pass. Each accepted character is
// classified combinationally; a completed quartet produces a job of one to three
// bytes, and the final character marks the last job. Jobs enter a four-entry
// queue and leave it one result per cycle while result_stall is low, through a
// registered output, so characters are taken every cycle while results drain;
// the input stalls only while the queue is full. Results pass from the queue
// entries into the output register. The last result of a string carries
// end_of_string, its status and the byte count saturated at 2^COUNT_WIDTH-1 and
// shown in its low 16 bits; after an error no bytes come out until the final
// character, which yields one status result.
module base64_validating_decoder_unit #(
    parameter int COUNT_WIDTH = b64vd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        final_char,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       out_byte,
    output logic             byte_present,
    output logic             end_of_string,
    output logic [1:0]       status,
    output logic [15:0]      decoded_count
);

    import b64vd_pkg::*;

    q_ctrl_t q_ctrl;
    q_stat_t q_stat;
    job_t    push_job;
    job_t    head;
    logic    push;
    logic    pop;

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    b64vd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .final_char (final_char),
        .q_stat     (q_stat),
        .push       (push),
        .job        (push_job)
    );

    b64vd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_ctrl   (q_ctrl),
        .push_job (push_job),
        .head     (head),
        .q_stat   (q_stat)
    );

    b64vd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .out_byte      (out_byte),
        .byte_present  (byte_present),
        .end_of_string (end_of_string),
        .status        (status),
        .decoded_count (decoded_count)
    );

    `B64VD_ASSERT_NEXT(a_queue_drains, !q_stat.empty, result_valid, "pending request not presented")
    `B64VD_ASSERT_IMPLIES(a_no_overflow, q_stat.full, !q_ctrl.push, "job queue overflow")
    `B64VD_ASSERT_IMPLIES(a_status_closes, result_valid && status != ST_OK,
                          end_of_string && !byte_present, "error status on a data request")

endmodule

`default_nettype wire

>>> sim/tb_base64_validating_decoder_unit.sv
// Self-checking testbench for the Base64 validating decoder: directed table plus random strings,
// checked result by result against a cycle-free decoder predictor.
// Depends on b64vd_pkg and base64_validating_decoder_unit.
`timescale 1ns / 1ps

module tb_base64_validating_decoder_unit;
    import b64vd_pkg::*;

    localparam int CNT_W      = COUNT_WIDTH_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int ITEM_GOAL  = 420;

    typedef struct packed {
        logic [7:0]  data;
        logic        present;
        logic        eos;
        status_t     st;
        logic [15:0] count;
    } b64_result_t;

    typedef struct packed {
        logic [7:0]  code;
        logic        fin;
        logic        typed;
        b64_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_stall;
    logic [7:0]  char_code = 8'h00;
    logic        final_char = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        end_of_string;
    logic [1:0]  status;
    logic [15:0] decoded_count;

    string       b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    b64_result_t pending_results[$];
    stim_row_t   directed_rows[$];
    logic [7:0]  line_buf[$];

    logic [17:0]      dec_acc;
    logic [1:0]       dec_pos;
    logic [1:0]       dec_pads;
    logic             dec_pad_done;
    status_t          dec_err;
    logic [CNT_W-1:0] dec_count;

    int mismatch_count = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    bit hold_off_req = 1'b0;

    base64_validating_decoder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_code     (char_code),
        .final_char    (final_char),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .out_byte      (out_byte),
        .byte_present  (byte_present),
        .end_of_string (end_of_string),
        .status        (status),
        .decoded_count (decoded_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int sextet_of(input logic [7:0] c);
        if (c == CH_PAD)
            return 64;
        for (int i = 0; i < 64; i++)
        begin
            if (b64_alpha[i] == c)
                return i;
        end
        return 65;
    endfunction

    function automatic logic [7:0] rand_alpha();
        return b64_alpha[$urandom_range(0, 63)];
    endfunction

    function automatic b64_result_t status_end(input status_t s, input int cnt);
        b64_result_t res;
        res.data    = 8'h00;
        res.present = 1'b0;
        res.eos     = 1'b1;
        res.st      = s;
        res.count   = cnt[15:0];
        return res;
    endfunction

    task automatic clear_decoder();
        dec_acc      = '0;
        dec_pos      = '0;
        dec_pads     = '0;
        dec_pad_done = 1'b0;
        dec_err      = ST_OK;
        dec_count    = '0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        b64_result_t res;
        if (~&dec_count)
            dec_count = dec_count + 1'b1;
        res.data    = b;
        res.present = 1'b1;
        res.eos     = 1'b0;
        res.st      = ST_OK;
        res.count   = dec_count[15:0];
        pending_results.push_back(res);
    endtask

    task automatic decode_char(input logic [7:0] c, input logic fin);
        int          v;
        int          first;
        logic [23:0] word;
        b64_result_t res;
        first = pending_results.size();
        if (dec_err == ST_OK)
        begin
            v = sextet_of(c);
            if (v == 65)
                dec_err = ST_BAD_CHAR;
            else if (dec_pad_done)
                dec_err = ST_PADDING;
            else if (v < 64)
            begin
                if (dec_pads != 0)
                    dec_err = ST_PADDING;
                else if (dec_pos < 3)
                begin
                    dec_acc = {dec_acc[11:0], 6'(v)};
                    dec_pos = dec_pos + 1'b1;
                end
                else
                begin
                    word = {dec_acc, 6'(v)};
                    push_byte(word[23:16]);
                    push_byte(word[15:8]);
                    push_byte(word[7:0]);
                    dec_acc = '0;
                    dec_pos = '0;
                end
            end
            else
            begin
                if (dec_pos < 2)
                    dec_err = ST_PADDING;
                else if (dec_pos == 2)
                begin
                    dec_pads = 2'd1;
                    dec_pos  = 2'd3;
                end
                else
                begin
                    if (dec_pads == 2'd1)
                        push_byte(dec_acc[11:4]);
                    else
                    begin
                        push_byte(dec_acc[17:10]);
                        push_byte(dec_acc[9:2]);
                    end
                    dec_pad_done = 1'b1;
                    dec_pads     = '0;
                    dec_acc      = '0;
                    dec_pos      = '0;
                end
            end
        end
        if (fin)
        begin
            if (dec_err == ST_OK && dec_pos != 0)
                dec_err = ST_LENGTH;
            if (dec_err != ST_OK)
            begin
                while (pending_results.size() > first)
                    res = pending_results.pop_back();
                pending_results.push_back(status_end(dec_err, int'(dec_count[15:0])));
            end
            else if (pending_results.size() > first)
            begin
                res = pending_results.pop_back();
                res.eos = 1'b1;
                pending_results.push_back(res);
            end
            clear_decoder();
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_result();
        b64_result_t want;
        if (pending_results.size() == 0)
        begin
            flag_mismatch($sformatf("result byte %02h eos %0b with nothing expected",
                                    out_byte, end_of_string));
            return;
        end
        want = pending_results.pop_front();
        if (out_byte !== want.data)
            flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
        if (byte_present !== want.present)
            flag_mismatch($sformatf("byte_present %0b, want %0b", byte_present, want.present));
        if (end_of_string !== want.eos)
            flag_mismatch($sformatf("end_of_string %0b, want %0b", end_of_string, want.eos));
        if (status !== want.st)
            flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
        if (decoded_count !== want.count)
            flag_mismatch($sformatf("decoded_count %0d, want %0d", decoded_count, want.count));
    endtask

    task automatic offer_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        final_char <= fin;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        decode_char(c, fin);
        items_sent++;
    endtask

    task automatic wait_drained();
        char_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic add_char(input logic [7:0] c, input logic fin);
        stim_row_t row;
        row.code  = c;
        row.fin   = fin;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_end(input logic [7:0] c, input status_t s, input int cnt);
        stim_row_t row;
        row.code  = c;
        row.fin   = 1'b1;
        row.typed = 1'b1;
        row.want  = status_end(s, cnt);
        directed_rows.push_back(row);
    endtask

    task automatic build_clean(input int nq);
        int pads;
        line_buf.delete();
        pads = $urandom_range(0, 2);
        repeat (nq * 4) line_buf.push_back(rand_alpha());
        if (pads > 0)
            line_buf[line_buf.size() - 1] = CH_PAD;
        if (pads > 1)
            line_buf[line_buf.size() - 2] = CH_PAD;
    endtask

    task automatic mutate_line();
        int k;
        int pos;
        k   = $urandom_range(0, 3);
        pos = $urandom_range(0, line_buf.size() - 1);
        case (k)
            0: line_buf[pos] = 8'($urandom_range(0, 255));
            1: line_buf[pos] = CH_PAD;
            2:
            begin
                if (line_buf.size() > 1)
                    void'(line_buf.pop_back());
            end
            default:
            begin
                repeat ($urandom_range(1, 5))
                    line_buf.push_back($urandom_range(0, 1) ? CH_PAD : rand_alpha());
            end
        endcase
    endtask

    task automatic build_noise();
        int r;
        line_buf.delete();
        repeat ($urandom_range(1, 8))
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                line_buf.push_back(CH_PAD);
            else if (r < 60)
                line_buf.push_back(rand_alpha());
            else
                line_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            offer_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    initial
    begin : result_sink
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                check_result();
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold = 60;
            end
            else if (hold == 0)
                hold = pick_gap();
            result_stall <= (hold != 0);
            if (hold != 0)
                hold--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[base64_validating_decoder_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        bit        squeezed;
        bit        paused;
        int        r;
        b64_result_t discard;
        squeezed = 1'b0;
        paused   = 1'b0;
        clear_decoder();

        add_end(CH_PAD, ST_PADDING, 0);
        add_end(8'hFF, ST_BAD_CHAR, 0);
        add_end(8'h00, ST_BAD_CHAR, 0);
        add_end("A", ST_LENGTH, 0);
        add_char("/", 1'b0);
        add_char("/", 1'b0);
        add_char("/", 1'b0);
        add_char("/", 1'b1);
        add_char("A", 1'b0);
        add_char("A", 1'b0);
        add_char(CH_PAD, 1'b0);
        add_char(CH_PAD, 1'b1);
        add_char("+", 1'b0);
        add_char("z", 1'b0);
        add_char("9", 1'b0);
        add_char(CH_PAD, 1'b1);
        add_char("A", 1'b0);
        add_char("B", 1'b0);
        add_char(CH_PAD, 1'b0);
        add_end("C", ST_PADDING, 0);
        add_char("Q", 1'b0);
        add_char("Q", 1'b0);
        add_char(CH_PAD, 1'b0);
        add_char(CH_PAD, 1'b0);
        add_end("A", ST_PADDING, 1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_char(directed_rows[i].code, directed_rows[i].fin);
            if (directed_rows[i].typed)
            begin
                discard = pending_results.pop_back();
                pending_results.push_back(directed_rows[i].want);
            end
        end
        wait_drained();

        while (items_sent < ITEM_GOAL)
        begin
            if (!squeezed && items_sent >= 160)
            begin
                // hold the sink off while the source streams back to back
                squeezed     = 1'b1;
                calm         = 1'b1;
                hold_off_req = 1'b1;
                build_clean(5);
                send_line();
                build_clean(4);
                send_line();
                calm = 1'b0;
            end
            else if (!paused && items_sent >= 300)
            begin
                paused = 1'b1;
                wait_drained();
            end
            else
            begin
                calm = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 99);
                if (r < 65)
                    build_clean($urandom_range(1, 4));
                else if (r < 88)
                begin
                    build_clean($urandom_range(1, 3));
                    mutate_line();
                end
                else
                    build_noise();
                send_line();
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[base64_validating_decoder_unit] OK");
        else
            $display("[base64_validating_decoder_unit] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/b64vd_pkg.sv
sv/b64vd_front.sv
sv/b64vd_queue.sv
sv/b64vd_back.sv
sv/base64_validating_decoder_unit.sv
sim/tb_base64_validating_decoder_unit.sv
